### hdl/phrg_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and arithmetic helpers of the pair hash generator
package phrg_pkg;

  localparam int unsigned SEED_W     = 31;
  localparam int unsigned TEA_ROUNDS = 8;
  // premix 10, rounds, finish hash 2, fixed-point scaling 4
  localparam int unsigned LATENCY    = 16 + TEA_ROUNDS;

  localparam logic [SEED_W-1:0] SEED_RESET = SEED_W'(1);

  localparam logic [31:0] MIX_K1 = 32'hA536_6B4D;
  localparam logic [31:0] MIX_K2 = 32'h72BE_1579;
  localparam logic [31:0] MIX_K3 = 32'h3F38_A6ED;
  localparam logic [31:0] MIX_K4 = 32'h79DE_DEA3;
  localparam logic [31:0] MIX_K5 = 32'hDDDF_97F5;
  localparam logic [31:0] MIX_K6 = 32'hABCB_96F7;
  localparam logic [31:0] TEA_DELTA = 32'h9E37_79B9;
  localparam logic [31:0] TEA_KA = 32'hA341_316C;
  localparam logic [31:0] TEA_KB = 32'hC801_3EA4;
  localparam logic [31:0] TEA_KC = 32'hAD90_777D;
  localparam logic [31:0] TEA_KD = 32'h7E95_761E;
  localparam logic [31:0] FIN_K  = 32'h6957_F5A7;

  // sqrt(3) = 1.BB67AE85_84CAA73B... (hex), fraction bits split in halves
  localparam logic [31:0] SQ3_HI = 32'hBB67_AE85;
  localparam logic [31:0] SQ3_LO = 32'h84CA_A73B;

  typedef struct packed {
    logic [31:0] first_tag;
    logic [31:0] second_tag;
    logic [31:0] time_step;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        random_word;
    logic signed [31:0] random_value;
  } out_item_t;

  typedef struct packed {
    logic [31:0] st;
    logic [31:0] ws;
  } tea_st_t;

  function automatic logic [31:0] mul32(input logic [31:0] x, input logic [31:0] y);
    logic [63:0] p;
    p = 64'(x) * 64'(y);
    return p[31:0];
  endfunction

  function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
    logic signed [31:0] s;
    s = x;
    s = s >>> n;
    return s;
  endfunction

  // running tea sum after n rounds
  function automatic logic [31:0] tea_sum(input int unsigned n);
    logic [63:0] p;
    p = 64'(TEA_DELTA) * 64'(n);
    return p[31:0];
  endfunction

endpackage

### hdl/phrg_tea_round.sv
`timescale 1ns / 1ps
// one registered tea round of the hash pipeline
module phrg_tea_round (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [31:0]      round_sum,
  input  logic             valid_in,
  input  phrg_pkg::tea_st_t st_in,
  output logic             valid_out,
  output phrg_pkg::tea_st_t st_out
);
  import phrg_pkg::*;

  logic    valid_r;
  tea_st_t st_r;
  tea_st_t st_nxt;

  always_comb begin
    st_nxt.st = st_in.st + (((st_in.ws << 4) + TEA_KA) ^ (st_in.ws + round_sum)
                ^ ((st_in.ws >> 5) + TEA_KB));
    st_nxt.ws = st_in.ws + (((st_nxt.st << 4) + TEA_KC) ^ (st_nxt.st + round_sum)
                ^ ((st_nxt.st >> 5) + TEA_KD));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
  end

  assign valid_out = valid_r;
  assign st_out    = st_r;

endmodule

### hdl/phrg_scale.sv
`timescale 1ns / 1ps
// four-stage conversion of the hash word to sqrt(3)-scaled fixed point
module phrg_scale (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               valid_in,
  input  logic [31:0]        word_in,
  output logic               valid_out,
  output phrg_pkg::out_item_t item_out
);
  import phrg_pkg::*;

  logic [3:0]  v_r;
  logic [31:0] w1_r, w2_r, w3_r;
  logic        neg1_r, neg2_r, neg3_r;
  logic [31:0] mag1_r, mag2_r, mag3_r;
  logic [31:0] p0hi_r;
  logic [64:0] acc_r;
  out_item_t   item_r;

  logic [31:0] mag_nxt;
  logic [63:0] p0_nxt;
  logic [63:0] hi_prod;
  logic [64:0] acc_nxt;
  logic [65:0] full_sum;
  logic [31:0] q;
  out_item_t   item_nxt;

  // distance from mid-scale; w = 0 gives a magnitude of 2^31
  assign mag_nxt = word_in[31] ? {1'b0, word_in[30:0]} : 32'h8000_0000 - word_in;

  assign p0_nxt  = 64'(mag1_r) * 64'(SQ3_LO);
  assign hi_prod = 64'(mag2_r) * 64'(SQ3_HI);
  assign acc_nxt = 65'(hi_prod) + 65'(p0hi_r);

  // floor(mag * 1.BB67AE8584CAA73B / 2); 64 fraction bits keep the floor exact
  assign full_sum = 66'({mag3_r, 32'h0}) + 66'(acc_r);
  assign q        = full_sum[64:33];

  always_comb begin
    item_nxt.random_word = w3_r;
    // negative side rounds down past the irrational product
    if (neg3_r && (mag3_r != 32'h0)) begin
      item_nxt.random_value = ~q;
    end else begin
      item_nxt.random_value = q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[2:0], valid_in};
    end
  end

  always_ff @(posedge clk) begin
    w1_r   <= word_in;
    neg1_r <= ~word_in[31];
    mag1_r <= mag_nxt;
    w2_r   <= w1_r;
    neg2_r <= neg1_r;
    mag2_r <= mag1_r;
    p0hi_r <= p0_nxt[63:32];
    w3_r   <= w2_r;
    neg3_r <= neg2_r;
    mag3_r <= mag2_r;
    acc_r  <= acc_nxt;
    item_r <= item_nxt;
  end

  assign valid_out = v_r[3];
  assign item_out  = item_r;

endmodule

### hdl/pair_hash_random_generator_unit.sv
`timescale 1ns / 1ps
// pair hash random generator: premix, tea rounds, final hash and scaling
// A fully pipelined counter hash: it takes one pair word on every clock (busy is always
// low) and gives its result exactly LATENCY = 16 + TEA_ROUNDS cycles later (24 with eight
// rounds), as a one-cycle out_strobe pulse that the receiver must take; there is no stall.
// The depth comes from the chain of seven dependent 32x32 multiplies in the premix and
// final hash, one tea round per stage, and four stages of the sqrt(3) fixed-point scaling.
// A seed written through cfg_we applies to words accepted after the write.
module pair_hash_random_generator_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  phrg_pkg::in_item_t           in_item,
  input  logic                         cfg_we,
  input  logic [phrg_pkg::SEED_W-1:0]  cfg_wdata,
  output logic                         out_strobe,
  output phrg_pkg::out_item_t          out_item
);
  import phrg_pkg::*;

  localparam int unsigned PRE_DEPTH = 10;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } mix_t;

  logic [SEED_W-1:0]    seed_r;
  logic [PRE_DEPTH-1:0] pre_v_r;
  mix_t                 m1_r, m2_r, m3_r, m4_r, m5_r, m6_r, m7_r;
  mix_t                 m1_nxt, m2_nxt, m3_nxt, m4_nxt, m5_nxt, m6_nxt, m7_nxt;
  tea_st_t              t8_r, t9_r, t10_r;
  tea_st_t              t8_nxt, t9_nxt, t10_nxt;

  tea_st_t              tea_st [TEA_ROUNDS+1];
  logic [TEA_ROUNDS:0]  tea_v;

  logic [1:0]           fin_v_r;
  logic [31:0]          fx_r, fw_r;
  logic [31:0]          fv, fx_nxt, fw_nxt;

  logic                 in_swap;

  // pipeline takes a word every cycle
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RESET;
    end else if (cfg_we) begin
      seed_r <= cfg_wdata;
    end
  end

  assign in_swap = in_item.first_tag > in_item.second_tag;

  always_comb begin
    m1_nxt.a = in_swap ? in_item.second_tag : in_item.first_tag;
    m1_nxt.b = in_swap ? in_item.first_tag : in_item.second_tag;
    m1_nxt.c = {1'b0, seed_r} + in_item.time_step;

    m2_nxt.c = m1_r.c ^ (m1_r.a << 7) ^ (m1_r.b >> 6);
    m2_nxt.b = m1_r.b + ((m1_r.a >> 4) ^ (m2_nxt.c >> 15));
    m2_nxt.a = m1_r.a ^ ((m2_nxt.b << 9) + (m2_nxt.c << 8));

    m3_nxt   = m2_r;
    m3_nxt.c = m2_r.c ^ mul32(MIX_K1, (m2_r.b >> 11) ^ (m2_r.a << 1));

    m4_nxt   = m3_r;
    m4_nxt.b = m3_r.b + mul32(MIX_K2, (m3_r.a << 4) ^ (m3_r.c >> 16));

    m5_nxt   = m4_r;
    m5_nxt.a = m4_r.a ^ mul32(MIX_K3, (m4_r.c >> 5) ^ asr32(m4_r.b, 22));

    m6_nxt   = m5_r;
    m6_nxt.b = m5_r.b + mul32(m5_r.a, m5_r.c);

    m7_nxt   = m6_r;
    m7_nxt.a = m6_r.a + (m6_r.c ^ (m6_r.b >> 2));
    m7_nxt.b = m6_r.b ^ asr32(m6_r.b, 17);

    // ws carries b until the state word is known
    t8_nxt.st = mul32(MIX_K4, m7_r.a ^ asr32(m7_r.a, 14));
    t8_nxt.ws = m7_r.b;

    t9_nxt.st = t8_r.st;
    t9_nxt.ws = (t8_r.st + t8_r.ws) ^ asr32(t8_r.st, 8);

    t10_nxt.st = t9_r.st + mul32(t9_r.ws, t9_r.ws ^ MIX_K5);
    t10_nxt.ws = MIX_K6 + (t9_r.ws >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_v_r <= '0;
    end else begin
      pre_v_r <= {pre_v_r[PRE_DEPTH-2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    m1_r  <= m1_nxt;
    m2_r  <= m2_nxt;
    m3_r  <= m3_nxt;
    m4_r  <= m4_nxt;
    m5_r  <= m5_nxt;
    m6_r  <= m6_nxt;
    m7_r  <= m7_nxt;
    t8_r  <= t8_nxt;
    t9_r  <= t9_nxt;
    t10_r <= t10_nxt;
  end

  assign tea_st[0] = t10_r;
  assign tea_v[0]  = pre_v_r[PRE_DEPTH-1];

  for (genvar gi = 0; gi < TEA_ROUNDS; gi++) begin : g_round
    phrg_tea_round u_round (
      .clk       (clk),
      .rst_n     (rst_n),
      .round_sum (tea_sum(gi + 1)),
      .valid_in  (tea_v[gi]),
      .st_in     (tea_st[gi]),
      .valid_out (tea_v[gi+1]),
      .st_out    (tea_st[gi+1])
    );
  end

  assign fv     = (tea_st[TEA_ROUNDS].st ^ (tea_st[TEA_ROUNDS].st >> 26))
                  + tea_st[TEA_ROUNDS].ws;
  assign fx_nxt = fv ^ (fv >> 20);
  assign fw_nxt = mul32(fx_r, FIN_K);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= '0;
    end else begin
      fin_v_r <= {fin_v_r[0], tea_v[TEA_ROUNDS]};
    end
  end

  always_ff @(posedge clk) begin
    fx_r <= fx_nxt;
    fw_r <= fw_nxt;
  end

  phrg_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (fin_v_r[1]),
    .word_in   (fw_r),
    .valid_out (out_strobe),
    .item_out  (out_item)
  );

  // every accepted word comes out after the fixed latency
  a_latency_fwd : assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LATENCY out_strobe)
    else $error("accepted word did not produce a result on time");

  // no result without a word accepted at the fixed latency before
  a_latency_bwd : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start, LATENCY))
    else $error("result strobe without matching accepted word");

  // scaled value lies below zero exactly for words below mid-scale
  a_value_sign : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_item.random_value[31] != out_item.random_word[31]))
    else $error("scaled value sign disagrees with word");

endmodule

### tb/sv/tb_pair_hash_random_generator_unit.sv
`timescale 1ns / 1ps
// self-checking testbench of the pair hash random generator unit
class pair_hash_tracker;
  localparam logic [31:0] PK1 = 32'hA536_6B4D;
  localparam logic [31:0] PK2 = 32'h72BE_1579;
  localparam logic [31:0] PK3 = 32'h3F38_A6ED;
  localparam logic [31:0] PK4 = 32'h79DE_DEA3;
  localparam logic [31:0] PK5 = 32'hDDDF_97F5;
  localparam logic [31:0] PK6 = 32'hABCB_96F7;
  localparam logic [31:0] DELTA = 32'h9E37_79B9;
  localparam logic [31:0] RK_A = 32'hA341_316C;
  localparam logic [31:0] RK_B = 32'hC801_3EA4;
  localparam logic [31:0] RK_C = 32'hAD90_777D;
  localparam logic [31:0] RK_D = 32'h7E95_761E;
  localparam logic [31:0] FK = 32'h6957_F5A7;
  localparam int ROUNDS = 8;
  localparam int SHOWN = 10;

  logic [30:0] seed;
  phrg_pkg::out_item_t awaited_words[$];
  int n_pairs;
  int n_words;
  int n_errors;

  function new();
    seed = 31'd1;
    n_pairs = 0;
    n_words = 0;
    n_errors = 0;
  endfunction

  function void load_seed(logic [30:0] s);
    seed = s;
  endfunction

  function int pending();
    return awaited_words.size();
  endfunction

  function void flag(string msg);
    n_errors++;
    if (n_errors <= SHOWN) $display("%0t: mismatch: %s", $time, msg);
  endfunction

  function logic [31:0] shift_sign(logic [31:0] x, int n);
    logic signed [31:0] s;
    s = x;
    return s >>> n;
  endfunction

  function logic [31:0] hash_pair(logic [31:0] a, logic [31:0] b, logic [31:0] ts);
    logic [31:0] c, st, ws, sum, v, h;
    c = {1'b0, seed} + ts;
    c ^= (a << 7) ^ (b >> 6);
    b += (a >> 4) ^ (c >> 15);
    a ^= (b << 9) + (c << 8);
    c ^= PK1 * ((b >> 11) ^ (a << 1));
    b += PK2 * ((a << 4) ^ (c >> 16));
    a ^= PK3 * ((c >> 5) ^ shift_sign(b, 22));
    b += a * c;
    a += c ^ (b >> 2);
    b ^= shift_sign(b, 17);
    st = PK4 * (a ^ shift_sign(a, 14));
    ws = (st + b) ^ shift_sign(st, 8);
    st = st + ws * (ws ^ PK5);
    ws = PK6 + (ws >> 1);
    sum = '0;
    for (int r = 0; r < ROUNDS; r++) begin
      sum += DELTA;
      st += ((ws << 4) + RK_A) ^ (ws + sum) ^ ((ws >> 5) + RK_B);
      ws += ((st << 4) + RK_C) ^ (st + sum) ^ ((st >> 5) + RK_D);
    end
    v = (st ^ (st >> 26)) + ws;
    h = (v ^ (v >> 20)) * FK;
    return h;
  endfunction

  function logic [63:0] isqrt_u64(logic [63:0] n);
    logic [63:0] root, bitv;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // floor(sqrt3 * (w - 2^31) / 2), exact through the integer root of 3*d^2
  function logic [31:0] sqrt3_scale(logic [31:0] w);
    logic [63:0] mag, q, nq;
    logic neg;
    neg = ~w[31];
    if (neg) mag = 64'h8000_0000 - {32'b0, w};
    else mag = {32'b0, w} - 64'h8000_0000;
    q = isqrt_u64(64'd3 * mag * mag) >> 1;
    nq = 64'd0 - (q + 64'd1);
    if (neg && mag != 0) return nq[31:0];
    return q[31:0];
  endfunction

  function void take_pair(phrg_pkg::in_item_t it);
    phrg_pkg::out_item_t e;
    logic [31:0] lo, hi;
    lo = (it.first_tag <= it.second_tag) ? it.first_tag : it.second_tag;
    hi = (it.first_tag <= it.second_tag) ? it.second_tag : it.first_tag;
    e.random_word = hash_pair(lo, hi, it.time_step);
    e.random_value = sqrt3_scale(e.random_word);
    awaited_words.push_back(e);
    n_pairs++;
  endfunction

  function void match_word(phrg_pkg::out_item_t got);
    phrg_pkg::out_item_t e;
    if (awaited_words.size() == 0) begin
      flag($sformatf("unexpected word %h / %0d", got.random_word, got.random_value));
      return;
    end
    e = awaited_words.pop_front();
    n_words++;
    if (got.random_word !== e.random_word)
      flag($sformatf("random_word exp %h got %h", e.random_word, got.random_word));
    if (got.random_value !== e.random_value)
      flag($sformatf("random_value exp %0d got %0d (word %h)",
                     e.random_value, got.random_value, e.random_word));
  endfunction

  function void close();
    if (awaited_words.size() != 0)
      flag($sformatf("%0d words never arrived", awaited_words.size()));
  endfunction
endclass

module tb_pair_hash_random_generator_unit;
  import phrg_pkg::*;

  localparam int DRAIN_CYCLES = 32;
  localparam int STALL_LIMIT = 2000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_item_t in_item;
  logic cfg_we;
  logic [SEED_W-1:0] cfg_wdata;
  logic out_strobe;
  out_item_t out_item;

  pair_hash_tracker book = new();
  int idle_run = 0;
  int seeds_used;

  pair_hash_random_generator_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // pre-edge values are seen here, so the order of drivers does not matter
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) book.load_seed(cfg_wdata);
      if (start && !busy) book.take_pair(in_item);
      if (out_strobe) book.match_word(out_item);
      if ((start && !busy) || out_strobe) idle_run <= 0;
      else idle_run <= idle_run + 1;
    end
  end

  initial begin
    while (idle_run < STALL_LIMIT) @(posedge clk);
    $display("watchdog: no traffic for %0d cycles", STALL_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  function automatic in_item_t junk_word();
    in_item_t it;
    it.first_tag = $urandom;
    it.second_tag = $urandom;
    it.time_step = $urandom;
    return it;
  endfunction

  // holds start high until the word is taken
  task automatic send_pair(input in_item_t it);
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      in_item <= junk_word();
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic drain();
    pause(1);
    while (book.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [SEED_W-1:0] s);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_wdata <= SEED_W'($urandom);
    seeds_used++;
  endtask

  task automatic send_tags(input logic [31:0] a, input logic [31:0] b, input logic [31:0] t);
    in_item_t it;
    it.first_tag = a;
    it.second_tag = b;
    it.time_step = t;
    send_pair(it);
  endtask

  task automatic run_directed();
    send_tags(32'h0, 32'h0, 32'h0);
    send_tags(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_tags(32'h0, 32'hFFFF_FFFF, 32'h0);
    send_tags(32'hFFFF_FFFF, 32'h0, 32'h0);
    send_tags(32'h0000_0005, 32'h0000_0005, 32'h0000_0064);
    send_tags(32'h0001_E240, 32'h0000_02A6, 32'h0000_0100);
    send_tags(32'h0000_02A6, 32'h0001_E240, 32'h0000_0100);
    pause(3);
    send_tags(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_tags(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555);
    send_tags(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
    // seed plus timestep wraps past 2^32
    send_tags(32'h0000_0001, 32'h0000_0002, 32'hFFFF_FFFF);
    send_tags(32'h0000_0002, 32'h0000_0001, 32'hFFFF_FFFE);
    send_tags(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    pause(1);
    send_tags(32'h0000_0001, 32'h8000_0000, 32'h8000_0001);
    send_tags(32'h8000_0000, 32'h8000_0000, 32'h0000_0001);
    send_tags(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_tags(32'h0000_0000, 32'h0000_0001, 32'h0000_0001);
    send_tags(32'h0000_0001, 32'h0000_0000, 32'h0000_0001);
  endtask

  function automatic in_item_t random_pair();
    in_item_t it;
    it = junk_word();
    case ($urandom_range(0, 9))
      5: it.second_tag = it.first_tag;
      6: begin
        it.first_tag = $urandom_range(0, 255);
        it.second_tag = $urandom_range(0, 255);
        it.time_step = $urandom_range(0, 1000);
      end
      7: begin
        it.first_tag = 32'hFFFF_FFFF - $urandom_range(0, 255);
        it.second_tag = 32'hFFFF_FFFF - $urandom_range(0, 255);
      end
      8: it.second_tag = it.first_tag + $urandom_range(0, 7) - 3;
      9: it.time_step = 32'hFFFF_FFFF - $urandom_range(0, 1 << 20);
      default: ;
    endcase
    return it;
  endfunction

  task automatic run_random(input int count, input bit with_gaps);
    int left, burst, gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      repeat (burst) send_pair(random_pair());
      left -= burst;
      gap = 0;
      if (with_gaps) begin
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 7) == 0) gap = $urandom_range(7, 20);
      end
      pause(gap);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    seeds_used = 1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    run_random(200, 1'b1);

    write_seed(31'h7FFF_FFFF);
    run_directed();
    run_random(200, 1'b0);

    // zero lies outside the intended seed range but is used as is
    write_seed(31'h0);
    run_random(150, 1'b1);

    write_seed(SEED_W'($urandom_range(2, 32'h7FFF_FFFE)));
    run_random(250, 1'b1);

    write_seed(31'h1);
    run_random(100, 1'b0);

    write_seed(SEED_W'($urandom));
    run_random(200, 1'b1);

    drain();
    book.close();
    $display("covered %0d pairs under %0d seed settings (1, max, zero and random)",
             book.n_pairs, seeds_used);
    $display("%0d words compared, %0d mismatches", book.n_words, book.n_errors);
    if (book.n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
